FILE: rtl/core/mme_pkg.sv
// Shared constants, types and helpers for the matrix multiply engine.
// Used by mme_mac and matrix_multiply_engine_core; depends on nothing.
package mme_pkg;

  // Sizing
  localparam int MAX_DIM  = 8;
  localparam int ELEM_W   = 16;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 35;
  localparam int DIM_W    = 4;
  localparam int DEPTH    = MAX_DIM * MAX_DIM;
  localparam int IDX_W    = $clog2(MAX_DIM);
  localparam int CNT_W    = $clog2(MAX_DIM + 1);
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int ACC_RAW  = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int ACC_W    = (ACC_RAW > OUT_W) ? ACC_RAW : OUT_W + 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;
  localparam logic [DIM_W-1:0]     DIM_RESET     = 4'd8;

  // Control from the sequencer to the MAC unit
  typedef struct packed {
    logic valid;  // operands on the MAC inputs are live
    logic clear;  // zero the accumulator
  } mac_ctrl_t;

  // Zero counts as 1, anything above MAX_DIM counts as MAX_DIM
  function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  // Store address of (row, col) in a MAX_DIM x MAX_DIM layout
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
  endfunction

  // Counter sits on the last position of a dimension
  function automatic logic at_end(input logic [IDX_W-1:0] cnt,
                                  input logic [CNT_W-1:0] dim);
    return (CNT_W'(cnt) + CNT_W'(1)) == dim;
  endfunction

endpackage

FILE: rtl/core/mme_mac.sv
// Shared multiply-accumulate unit: registered product, wide exact sum,
// saturated view of the sum at the output width. Depends on mme_pkg.
module mme_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mme_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [mme_pkg::ELEM_W-1:0] a_i,
  input  logic signed [mme_pkg::ELEM_W-1:0] b_i,
  output logic                              busy_o,
  output logic signed [mme_pkg::OUT_W-1:0]  result_o
);
  import mme_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_valid_q;
  logic signed [ACC_W-1:0]  acc_q;

  // Product stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= ctrl_i.valid;
    end
  end

  // Multiply, then accumulate
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (prod_valid_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign busy_o = prod_valid_q;

  // Clamp to the output range
  always_comb begin
    if (acc_q > SAT_MAX) begin
      result_o = OUT_W'(SAT_MAX);
    end else if (acc_q < SAT_MIN) begin
      result_o = OUT_W'(SAT_MIN);
    end else begin
      result_o = OUT_W'(acc_q);
    end
  end

endmodule

FILE: rtl/core/matrix_multiply_engine_core.sv
// Top level of the integer matrix multiply engine: element load, stores,
// dot-product sequencer and output register. Depends on mme_pkg, mme_mac.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+--------------------------
//   in       | in        | in_valid_i / in_stall_o | element_value_i
//   out      | out       | out_valid_o/ out_stall_i| product_value_o, is_last_o
//   cfg      | in        | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// Elements of A and B are loaded in row order, A first. The word completing B
// starts the products: each of the rows_a x cols_b results is computed on the
// single shared MAC (read, multiply, accumulate), one result at a time.
// Inputs and configuration are held off while products are computed, and a
// configuration word stalls the input. A stall on the output only delays the
// next dot product. Reset restores 8x8x8 and an empty load; the stores are
// not cleared.
module matrix_multiply_engine_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // element input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [mme_pkg::IN_W-1:0]      element_value_i,
  // result output
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mme_pkg::OUT_W-1:0]     product_value_o,
  output logic                                 is_last_o,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mme_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [mme_pkg::DIM_W-1:0]            cfg_data_i
);
  import mme_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MAC,
    ST_DRAIN
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   rows_a_q, inner_dim_q, cols_b_q;
  logic               phase_b_q;
  logic [IDX_W-1:0]   ld_row_q, ld_col_q;
  logic [IDX_W-1:0]   r_q, c_q, k_q;
  logic               rd_valid_q;
  logic               out_valid_q;
  logic signed [OUT_W-1:0] product_q;
  logic               is_last_q;

  logic signed [ELEM_W-1:0] mem_a [DEPTH];
  logic signed [ELEM_W-1:0] mem_b [DEPTH];
  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q;

  logic               in_acc, cfg_we, cfg_hit;
  logic [CNT_W-1:0]   row_lim, col_lim;
  logic               col_end, row_end, load_done;
  logic signed [ELEM_W-1:0] elem;
  logic [ADDR_W-1:0]  wr_addr, rd_addr_a, rd_addr_b;
  logic               issue, out_free, emit, last_res;
  mac_ctrl_t          mac_ctrl;
  logic               mac_busy;
  logic signed [OUT_W-1:0] mac_result;

  // Handshakes
  assign in_stall_o  = (state_q != ST_LOAD) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_we && ((cfg_index_i == CFG_ROWS_A) ||
                                  (cfg_index_i == CFG_INNER_DIM) ||
                                  (cfg_index_i == CFG_COLS_B));

  // Load position: A is rows_a x inner_dim, B is inner_dim x cols_b
  assign row_lim   = phase_b_q ? inner_dim_q : rows_a_q;
  assign col_lim   = phase_b_q ? cols_b_q    : inner_dim_q;
  assign col_end   = at_end(ld_col_q, col_lim);
  assign row_end   = at_end(ld_row_q, row_lim);
  assign load_done = phase_b_q && col_end && row_end;
  assign elem      = ELEM_W'(element_value_i);
  assign wr_addr   = elem_addr(ld_row_q, ld_col_q);

  // Dot-product sequencing
  assign issue     = (state_q == ST_MAC);
  assign rd_addr_a = elem_addr(r_q, k_q);
  assign rd_addr_b = elem_addr(k_q, c_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = (state_q == ST_DRAIN) && !rd_valid_q && !mac_busy && out_free;
  assign last_res  = at_end(r_q, rows_a_q) && at_end(c_q, cols_b_q);

  assign mac_ctrl.valid = rd_valid_q;
  assign mac_ctrl.clear = (state_q == ST_LOAD) || emit;

  // Element stores
  always_ff @(posedge clk_i) begin
    if (in_acc && !cfg_we && !phase_b_q) begin
      mem_a[wr_addr] <= elem;
    end
    if (in_acc && !cfg_we && phase_b_q) begin
      mem_b[wr_addr] <= elem;
    end
    a_rd_q <= mem_a[rd_addr_a];
    b_rd_q <= mem_b[rd_addr_b];
  end

  mme_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .a_i      (a_rd_q),
    .b_i      (b_rd_q),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  // Sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      rows_a_q    <= clamp_dim(DIM_RESET);
      inner_dim_q <= clamp_dim(DIM_RESET);
      cols_b_q    <= clamp_dim(DIM_RESET);
      phase_b_q   <= 1'b0;
      ld_row_q    <= '0;
      ld_col_q    <= '0;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      product_q   <= '0;
      is_last_q   <= 1'b0;
    end else begin
      rd_valid_q <= issue;
      // word taken and nothing new behind it
      if (out_valid_q && !out_stall_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (cfg_we) begin
            case (cfg_index_i)
              CFG_ROWS_A:    rows_a_q    <= clamp_dim(cfg_data_i);
              CFG_INNER_DIM: inner_dim_q <= clamp_dim(cfg_data_i);
              CFG_COLS_B:    cols_b_q    <= clamp_dim(cfg_data_i);
              default:       ;
            endcase
            if (cfg_hit) begin
              phase_b_q <= 1'b0;
              ld_row_q  <= '0;
              ld_col_q  <= '0;
            end
          end else if (in_acc) begin
            if (col_end) begin
              ld_col_q <= '0;
              if (row_end) begin
                ld_row_q  <= '0;
                phase_b_q <= !phase_b_q;
              end else begin
                ld_row_q <= ld_row_q + IDX_W'(1);
              end
            end else begin
              ld_col_q <= ld_col_q + IDX_W'(1);
            end
            if (load_done) begin
              state_q <= ST_MAC;
              r_q     <= '0;
              c_q     <= '0;
              k_q     <= '0;
            end
          end
        end
        ST_MAC: begin
          if (at_end(k_q, inner_dim_q)) begin
            k_q     <= '0;
            state_q <= ST_DRAIN;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            product_q   <= mac_result;
            is_last_q   <= last_res;
            if (last_res) begin
              state_q <= ST_LOAD;
            end else begin
              state_q <= ST_MAC;
              if (at_end(c_q, cols_b_q)) begin
                c_q <= '0;
                r_q <= r_q + IDX_W'(1);
              end else begin
                c_q <= c_q + IDX_W'(1);
              end
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign product_value_o = product_q;
  assign is_last_o       = is_last_q;

endmodule
